### rtl/core/brsc_pkg.sv
// Shared types and constants for the bitmap range set/clear/find block.
// No dependencies; imported by brsc_cell and bitmap_range_set_clear_find_top.
`default_nettype none

package brsc_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;

    localparam int POS_W   = 13;
    localparam int START_W = 12;
    localparam int COUNT_W = 13;
    localparam int CFG_W   = 7;
    localparam int OP_W    = 2;
    localparam int SH_W    = $clog2(WORD_BITS) + 1;
    localparam int IDX_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam int TOTAL_BITS  = NUM_WORDS * WORD_BITS;
    localparam int WORDS_RESET = 64;

    localparam logic [OP_W-1:0] OP_SET       = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND_ZERO = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND_ONE  = 2'd3;

    // Item travelling down the chain of cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [OP_W-1:0]    opcode;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   stop;
        logic [POS_W-1:0]   limit;
        logic               found;
        logic [POS_W-1:0]   pos;
    } brsc_link_t;

endpackage

`default_nettype wire

### rtl/core/brsc_cell.sv
// One cell of the bitmap chain: holds one word, applies set/clear ranges to it
// and continues the search. Depends on brsc_pkg.
`default_nettype none

module brsc_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [brsc_pkg::IDX_W-1:0] cell_index,
    input  wire brsc_pkg::brsc_link_t       link_in,
    output brsc_pkg::brsc_link_t            link_out
);
    import brsc_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    brsc_link_t           link_reg;
    brsc_link_t           link_next;

    logic [POS_W-1:0]     base;
    logic [POS_W-1:0]     base_top;
    logic [SH_W-1:0]      lo_off;
    logic [SH_W-1:0]      hi_off;
    logic [WORD_BITS-1:0] ge_mask;
    logic [WORD_BITS-1:0] lt_mask;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] cand;
    logic [SH_W-1:0]      lead;
    logic                 is_write;
    logic                 range_hit;
    logic                 search_on;

    assign base     = POS_W'(POS_W'(cell_index) * POS_W'(WORD_BITS));
    assign base_top = base + POS_W'(WORD_BITS);
    assign is_write = (link_in.opcode == OP_SET) || (link_in.opcode == OP_CLEAR);

    // Offsets of the range inside this word, MSB-first.
    always_comb
    begin
        if (link_in.start > base)
            lo_off = SH_W'(link_in.start - base);
        else
            lo_off = '0;
        if (link_in.stop >= base_top)
            hi_off = SH_W'(WORD_BITS);
        else
            hi_off = SH_W'(link_in.stop - base);
    end

    assign ge_mask    = {WORD_BITS{1'b1}} >> lo_off;
    assign lt_mask    = ~({WORD_BITS{1'b1}} >> hi_off);
    assign range_hit  = (link_in.start < base_top) && (link_in.stop > base);
    assign range_mask = range_hit ? (ge_mask & lt_mask) : '0;

    assign search_on = link_in.valid && !is_write && !link_in.found
                       && (base < link_in.limit) && (link_in.start < base_top);
    assign cand = ((link_in.opcode == OP_FIND_ONE) ? word_reg : ~word_reg) & ge_mask;

    // First set bit from the MSB side.
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (cand[i])
                lead = SH_W'(WORD_BITS - 1 - i);
        end
    end

    always_comb
    begin
        word_next = word_reg;
        link_next = link_in;
        if (link_in.valid && is_write)
        begin
            if (link_in.opcode == OP_SET)
                word_next = word_reg | range_mask;
            else
                word_next = word_reg & ~range_mask;
        end
        if (search_on && (cand != '0))
        begin
            link_next.found = 1'b1;
            link_next.pos   = base + POS_W'(lead);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            link_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire

### rtl/core/bitmap_range_set_clear_find_top.sv
// Top level of the bitmap range set/clear/find block: a row of word cells,
// the input/output handshakes and the words_in_use register. Depends on
// brsc_pkg and brsc_cell.
`default_nettype none

// The bitmap is a row of NUM_WORDS cells, one word each; bit position 0 is the
// MSB of word 0. An accepted item walks down the row one cell per cycle: set
// and clear ranges update each word they cover, and finds carry the first
// match along so far; a find's result then waits in the result register.
// One item is worked on at a time: a set or clear frees the block when it
// leaves the last cell, and a find frees it when its result is taken. Finds
// search the first min(words_in_use, NUM_WORDS) words and report that many
// words times WORD_BITS with not_found raised when nothing matches.
// The bitmap clears at reset; words_in_use resets to 64 and is written through
// the cfg channel, which is ready whenever no item is in flight.
module bitmap_range_set_clear_find_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration write channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [brsc_pkg::CFG_W-1:0]   cfg_data,
    // item input
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [brsc_pkg::OP_W-1:0]    opcode,
    input  wire logic [brsc_pkg::START_W-1:0] start_position,
    input  wire logic [brsc_pkg::COUNT_W-1:0] bit_count,
    // result output
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [brsc_pkg::POS_W-1:0]        found_position,
    output logic                              not_found
);
    import brsc_pkg::*;

    logic [CFG_W-1:0] words_in_use_reg;
    logic             busy_reg;
    logic             busy_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [POS_W-1:0] found_pos_reg;
    logic             not_found_reg;

    logic             in_accept;
    logic             out_accept;
    logic [POS_W:0]   range_end;
    logic [POS_W-1:0] stop_clip;
    logic [POS_W-1:0] limit;
    logic             last_is_write;

    brsc_link_t chain [NUM_WORDS+1];

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = busy_reg;
    assign cfg_ready  = !busy_reg;

    // Clip the range end to the bitmap size; one extra bit holds the full sum.
    assign range_end = (POS_W+1)'(start_position) + (POS_W+1)'(bit_count);
    assign stop_clip = (int'(range_end) > TOTAL_BITS) ? POS_W'(TOTAL_BITS)
                                                      : POS_W'(range_end);

    // Search limit in bits; words beyond the bitmap are not searched.
    always_comb
    begin
        if (int'(words_in_use_reg) > NUM_WORDS)
            limit = POS_W'(TOTAL_BITS);
        else
            limit = POS_W'(POS_W'(words_in_use_reg) * POS_W'(WORD_BITS));
    end

    // Head of the chain: the item as accepted.
    always_comb
    begin
        chain[0].valid  = in_accept;
        chain[0].opcode = opcode;
        chain[0].start  = POS_W'(start_position);
        chain[0].stop   = stop_clip;
        chain[0].limit  = limit;
        chain[0].found  = 1'b0;
        chain[0].pos    = '0;
    end

    for (genvar k = 0; k < NUM_WORDS; k++)
    begin : g_cell
        brsc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (IDX_W'(k)),
            .link_in    (chain[k]),
            .link_out   (chain[k+1])
        );
    end

    assign last_is_write = (chain[NUM_WORDS].opcode == OP_SET)
                           || (chain[NUM_WORDS].opcode == OP_CLEAR);

    // Hold busy from accept until the item leaves the row (writes) or its
    // result is taken (finds).
    always_comb
    begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        if (out_accept)
        begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (chain[NUM_WORDS].valid)
        begin
            if (last_is_write)
                busy_next = 1'b0;
            else
                out_valid_next = 1'b1;
        end
        if (in_accept)
            busy_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            words_in_use_reg <= CFG_W'(WORDS_RESET);
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                words_in_use_reg <= cfg_data;
        end
    end

    // Capture the find result as it drops out of the last cell.
    always_ff @(posedge clk)
    begin
        if (chain[NUM_WORDS].valid && !last_is_write)
        begin
            found_pos_reg <= chain[NUM_WORDS].found ? chain[NUM_WORDS].pos
                                                    : chain[NUM_WORDS].limit;
            not_found_reg <= !chain[NUM_WORDS].found;
        end
    end

    assign out_valid      = out_valid_reg;
    assign found_position = found_pos_reg;
    assign not_found      = not_found_reg;

    // An item leaving the row always belongs to a busy block.
    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain[NUM_WORDS].valid |-> busy_reg)
        else $error("item left the cell row while block idle");

    // A pending result keeps the input closed.
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> busy_reg)
        else $error("result pending while block idle");

    // Accepting an item opens a busy period on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> busy_reg)
        else $error("accepted item did not mark block busy");

    // A found position lies inside the searched words.
    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !not_found_reg) |-> (found_pos_reg < limit))
        else $error("found position beyond searched words");

endmodule

`default_nettype wire
